@@ design/tssm_pkg.sv @@
// Package for the two-stacks-in-one-memory block: item types, operation and status codes.
// Has no dependencies. Used by two_stacks_shared_memory.
package tssm_pkg;

   localparam int WORD_W = 32;

   localparam logic [2:0] OP_PUSH_ONE = 3'd0;
   localparam logic [2:0] OP_PUSH_TWO = 3'd1;
   localparam logic [2:0] OP_POP_ONE  = 3'd2;
   localparam logic [2:0] OP_POP_TWO  = 3'd3;
   localparam logic [2:0] OP_DUMP_ONE = 3'd4;
   localparam logic [2:0] OP_DUMP_TWO = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   localparam logic signed [WORD_W-1:0] WORD_UNDERFLOW = -32'sd1;

   typedef struct packed {
      logic [2:0]               operation;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] word;
      logic                     last;
   } rsp_type;

endpackage

@@ design/tssm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/two_stacks_shared_memory.sv @@
// Top level: two stacks sharing one RAM, stack one growing up and stack two growing down.
// Depends on tssm_pkg and tssm_ram.
//
//   Port group   Dir   Handshake             Item
//   req_*        in    req_valid/req_stall   tssm_pkg::req_type (operation, value)
//   rsp_*        out   rsp_valid/rsp_stall   tssm_pkg::rsp_type (status, word, last)
//
// A push, a refused operation or an empty dump is answered in the cycle after it is taken.
// A pop reads the RAM, whose read is registered, then fills the output register when free.
// A dump reads one word per cycle from the RAM port while the output is not stalled. An
// item is taken only while no earlier item is still reading, and while the output register
// is empty or being emptied. Reset empties both stacks; the RAM contents are not cleared.
module two_stacks_shared_memory #(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tssm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tssm_pkg::rsp_type rsp_data
);

   import tssm_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(DEPTH);
   localparam logic [ADDR_W-1:0] TOP_C   = ADDR_W'(DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FETCH = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_low_ff, count_low_in;
   logic [CNT_W-1:0]  base_high_ff, base_high_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic              down_ff, down_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic              out_free;
   logic              accept;
   logic              full;
   logic [CNT_W-1:0]  count_dec;
   logic [CNT_W-1:0]  base_dec;
   logic [ADDR_W-1:0] cur_next;

   tssm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_low_ff == base_high_ff);
   assign count_dec = count_low_ff - 1'b1;
   assign base_dec  = base_high_ff - 1'b1;
   assign cur_next  = down_ff ? (cur_ff - 1'b1) : (cur_ff + 1'b1);

   always_comb begin
      state_in     = state_ff;
      count_low_in = count_low_ff;
      base_high_in = base_high_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      down_in      = down_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = count_low_ff[ADDR_W-1:0];
      wr_data      = req_data.value;
      rd_en        = 1'b0;
      rd_addr      = cur_next;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.operation)
                  OP_PUSH_ONE: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{status: STATUS_OK, word: req_data.value, last: 1'b1};
                     if (full) begin
                        rsp_data_in.status = STATUS_OVERFLOW;
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = count_low_ff[ADDR_W-1:0];
                        count_low_in = count_low_ff + 1'b1;
                     end
                  end
                  OP_PUSH_TWO: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{status: STATUS_OK, word: req_data.value, last: 1'b1};
                     if (full) begin
                        rsp_data_in.status = STATUS_OVERFLOW;
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = base_dec[ADDR_W-1:0];
                        base_high_in = base_dec;
                     end
                  end
                  OP_POP_ONE: begin
                     if (count_low_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: STATUS_UNDERFLOW, word: WORD_UNDERFLOW,
                                         last: 1'b1};
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = count_dec[ADDR_W-1:0];
                        count_low_in = count_dec;
                        cur_in       = count_dec[ADDR_W-1:0];
                        end_in       = count_dec[ADDR_W-1:0];
                        state_in     = ST_FETCH;
                     end
                  end
                  OP_POP_TWO: begin
                     if (base_high_ff == DEPTH_C) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: STATUS_UNDERFLOW, word: WORD_UNDERFLOW,
                                         last: 1'b1};
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = base_high_ff[ADDR_W-1:0];
                        base_high_in = base_high_ff + 1'b1;
                        cur_in       = base_high_ff[ADDR_W-1:0];
                        end_in       = base_high_ff[ADDR_W-1:0];
                        state_in     = ST_FETCH;
                     end
                  end
                  OP_DUMP_ONE: begin
                     if (count_low_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: STATUS_EMPTY, word: '0, last: 1'b1};
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        cur_in   = '0;
                        end_in   = count_dec[ADDR_W-1:0];
                        down_in  = 1'b0;
                        state_in = ST_FETCH;
                     end
                  end
                  OP_DUMP_TWO: begin
                     if (base_high_ff == DEPTH_C) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: STATUS_EMPTY, word: '0, last: 1'b1};
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = TOP_C;
                        cur_in   = TOP_C;
                        end_in   = base_high_ff[ADDR_W-1:0];
                        down_in  = 1'b1;
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: STATUS_OK, word: rd_data, last: (cur_ff == end_ff)};
               if (cur_ff == end_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = cur_next;
                  cur_in  = cur_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_low_ff <= '0;
         base_high_ff <= DEPTH_C;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_low_ff <= count_low_in;
         base_high_ff <= base_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      end_ff      <= end_in;
      down_ff     <= down_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
